@@ src/rc4_stream_cipher_top_macros.svh @@
// ----------------------------------------------------------------------------
// RC4 stream cipher - assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_TOP_MACROS_SVH
`define RC4_STREAM_CIPHER_TOP_MACROS_SVH

// same-cycle implication
`define RC4SC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RC4SC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/rc4sc_pkg.sv @@
// ----------------------------------------------------------------------------
// RC4 stream cipher - package
// Shared widths, register indexes and interface structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rc4sc_pkg;

  localparam int unsigned DATA_W        = 8;
  localparam int unsigned PERM_DEPTH    = 256;
  localparam int unsigned PERM_AW       = 8;
  localparam logic [PERM_AW-1:0] LAST_IDX = 8'hFF;

  localparam int unsigned KEY_REG_W     = 64;
  localparam int unsigned KEY_BYTES     = 16;
  localparam int unsigned KEY_IDX_W     = 4;
  localparam int unsigned KEY_LEN_W     = 5;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd16;
  localparam int unsigned MAX_KEY_BYTES_DEF = 16;

  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 2'd2;

  // key material as seen by the engine; len is the effective length
  typedef struct packed {
    logic [KEY_BYTES-1:0][DATA_W-1:0] key;
    logic [KEY_LEN_W-1:0]             len;
  } key_cfg_t;

  // permutation memory request
  typedef struct packed {
    logic               we;
    logic [PERM_AW-1:0] waddr;
    logic [DATA_W-1:0]  wdata;
    logic [PERM_AW-1:0] raddr;
  } mem_req_t;

endpackage

@@ src/rc4sc_ram.sv @@
// ----------------------------------------------------------------------------
// RC4 stream cipher - generic RAM
// One write port, one read port, registered read, read-first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc4sc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/rc4sc_cfg.sv @@
// ----------------------------------------------------------------------------
// RC4 stream cipher - configuration registers
// Key words and key length; produces the effective key length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc4sc_cfg #(
  parameter int unsigned MAX_KEY_BYTES = rc4sc_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rc4sc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rc4sc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output rc4sc_pkg::key_cfg_t                 key_cfg_o
);

  localparam logic [rc4sc_pkg::KEY_LEN_W-1:0] LenMax = rc4sc_pkg::KEY_LEN_W'(MAX_KEY_BYTES);

  logic [rc4sc_pkg::KEY_REG_W-1:0] key_low_q,  key_low_d;
  logic [rc4sc_pkg::KEY_REG_W-1:0] key_high_q, key_high_d;
  logic [rc4sc_pkg::KEY_LEN_W-1:0] key_len_q,  key_len_d;

  always_comb begin
    key_low_d  = key_low_q;
    key_high_d = key_high_q;
    key_len_d  = key_len_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rc4sc_pkg::CFG_KEY_LOW:    key_low_d  = cfg_data_i;
        rc4sc_pkg::CFG_KEY_HIGH:   key_high_d = cfg_data_i;
        rc4sc_pkg::CFG_KEY_LENGTH: key_len_d  = cfg_data_i[rc4sc_pkg::KEY_LEN_W-1:0];
        default: ;  // unused index
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      key_len_q  <= rc4sc_pkg::KEY_LEN_RESET;
    end else begin
      key_low_q  <= key_low_d;
      key_high_q <= key_high_d;
      key_len_q  <= key_len_d;
    end
  end

  // zero or oversize length saturates to the maximum
  assign key_cfg_o.key = {key_high_q, key_low_q};
  assign key_cfg_o.len = ((key_len_q == '0) || (key_len_q > LenMax)) ? LenMax : key_len_q;

endmodule

@@ src/rc4sc_engine.sv @@
// ----------------------------------------------------------------------------
// RC4 stream cipher - engine
// Sequencer over the permutation RAM: clear pass, key schedule, keystream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rc4_stream_cipher_top_macros.svh"

module rc4sc_engine #(
  parameter int unsigned MAX_KEY_BYTES = rc4sc_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rc4sc_pkg::key_cfg_t              key_cfg_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [rc4sc_pkg::DATA_W-1:0]     data_byte_i,
  input  logic                             restart_i,
  input  logic                             last_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [rc4sc_pkg::DATA_W-1:0]     out_byte_o,
  output logic                             last_out_o,
  output rc4sc_pkg::mem_req_t              mem_req_o,
  input  logic [rc4sc_pkg::DATA_W-1:0]     mem_rdata_i
);

  localparam int unsigned PosW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int unsigned AW   = rc4sc_pkg::PERM_AW;
  localparam int unsigned DW   = rc4sc_pkg::DATA_W;

  typedef enum logic [2:0] {
    ST_CLR,    // write identity, one entry per cycle
    ST_K_ACC,  // schedule: S[k] arrives, update acc, read S[acc]
    ST_K_W1,   // schedule: write S[k] = S[acc]
    ST_K_W2,   // schedule: write S[acc] = old S[k], read S[k+1]
    ST_IDLE,   // accept; finish previous byte if tail pending
    ST_RD_J,   // S[i] arrives, j += S[i], read S[j]
    ST_RD_K    // S[j] arrives, write S[i], read S[S[i]+S[j]]
  } state_e;

  state_e              state_q, state_d;
  logic [AW-1:0]       cnt_q, cnt_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic [DW-1:0]       acc_q, acc_d;
  logic [AW-1:0]       i_q, i_d;
  logic [AW-1:0]       j_q, j_d;
  logic [DW-1:0]       a_q, a_d;
  logic [AW-1:0]       t_q, t_d;
  logic [DW-1:0]       data_q, data_d;
  logic                last_q, last_d;
  logic                restart_q, restart_d;
  logic                tail_q, tail_d;
  logic                out_valid_q, out_valid_d;
  logic [DW-1:0]       out_byte_q, out_byte_d;
  logic                last_out_q, last_out_d;
  rc4sc_pkg::mem_req_t req_q;

  rc4sc_pkg::mem_req_t req;
  logic [DW-1:0]       rd_fwd;
  logic [DW-1:0]       ks;
  logic [DW-1:0]       acc_new;
  logic [AW-1:0]       j_new;
  logic                pos_last;
  logic                can_load;
  logic                in_ready;

  // RAM is read-first: a write to the address read in the same cycle is bypassed
  assign rd_fwd = (req_q.we && (req_q.waddr == req_q.raddr)) ? req_q.wdata : mem_rdata_i;

  // S[j] = a lands in the tail cycle, after the keystream read was issued
  assign ks       = (t_q == j_q) ? a_q : rd_fwd;
  assign acc_new  = acc_q + rd_fwd + key_cfg_i.key[rc4sc_pkg::KEY_IDX_W'(pos_q)];
  assign j_new    = j_q + rd_fwd;
  assign pos_last = (rc4sc_pkg::KEY_LEN_W'(pos_q) == (key_cfg_i.len - 1'b1));
  assign can_load = !out_valid_q || out_ready_i;
  assign in_ready = (state_q == ST_IDLE) && (!tail_q || can_load);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    acc_d       = acc_q;
    i_d         = i_q;
    j_d         = j_q;
    a_d         = a_q;
    t_d         = t_q;
    data_d      = data_q;
    last_d      = last_q;
    restart_d   = restart_q;
    tail_d      = tail_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    last_out_d  = last_out_q;
    req.we      = 1'b0;
    req.waddr   = cnt_q;
    req.wdata   = cnt_q;
    req.raddr   = i_q + 1'b1;

    unique case (state_q)
      ST_CLR: begin
        req.we    = 1'b1;
        req.waddr = cnt_q;
        req.wdata = cnt_q;
        req.raddr = '0;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == rc4sc_pkg::LAST_IDX) begin
          acc_d   = '0;
          pos_d   = '0;
          state_d = restart_q ? ST_K_ACC : ST_IDLE;
        end
      end
      ST_K_ACC: begin
        a_d       = rd_fwd;
        acc_d     = acc_new;
        req.raddr = acc_new;
        state_d   = ST_K_W1;
      end
      ST_K_W1: begin
        req.we    = 1'b1;
        req.waddr = cnt_q;
        req.wdata = rd_fwd;
        state_d   = ST_K_W2;
      end
      ST_K_W2: begin
        req.we    = 1'b1;
        req.waddr = acc_q;
        req.wdata = a_q;
        pos_d     = pos_last ? '0 : pos_q + 1'b1;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == rc4sc_pkg::LAST_IDX) begin
          // schedule done: i = 0, j = 0, then start the byte with i = 1
          req.raddr = AW'(1);
          i_d       = AW'(1);
          j_d       = '0;
          restart_d = 1'b0;
          state_d   = ST_RD_J;
        end else begin
          req.raddr = cnt_q + 1'b1;
          state_d   = ST_K_ACC;
        end
      end
      ST_IDLE: begin
        if (tail_q) begin
          req.we    = 1'b1;
          req.waddr = j_q;
          req.wdata = a_q;
          if (can_load) begin
            out_valid_d = 1'b1;
            out_byte_d  = data_q ^ ks;
            last_out_d  = last_q;
            tail_d      = 1'b0;
          end else begin
            req.raddr = t_q;  // hold the keystream read while stalled
          end
        end
        if (in_valid_i && in_ready) begin
          data_d = data_byte_i;
          last_d = last_byte_i;
          i_d    = i_q + 1'b1;
          if (restart_i) begin
            restart_d = 1'b1;
            cnt_d     = '0;
            state_d   = ST_CLR;
          end else begin
            state_d   = ST_RD_J;
          end
        end
      end
      ST_RD_J: begin
        a_d       = rd_fwd;
        j_d       = j_new;
        req.raddr = j_new;
        state_d   = ST_RD_K;
      end
      ST_RD_K: begin
        req.we    = 1'b1;
        req.waddr = i_q;
        req.wdata = rd_fwd;
        req.raddr = a_q + rd_fwd;
        t_d       = a_q + rd_fwd;
        tail_d    = 1'b1;
        state_d   = ST_IDLE;
      end
      default: state_d = ST_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      cnt_q       <= '0;
      pos_q       <= '0;
      acc_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      a_q         <= '0;
      t_q         <= '0;
      data_q      <= '0;
      last_q      <= 1'b0;
      restart_q   <= 1'b0;
      tail_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      last_out_q  <= 1'b0;
      req_q       <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      acc_q       <= acc_d;
      i_q         <= i_d;
      j_q         <= j_d;
      a_q         <= a_d;
      t_q         <= t_d;
      data_q      <= data_d;
      last_q      <= last_d;
      restart_q   <= restart_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
      out_byte_q  <= out_byte_d;
      last_out_q  <= last_out_d;
      req_q       <= req;
    end
  end

  assign mem_req_o   = req;
  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_out_o  = last_out_q;

  `RC4SC_ASSERT_NEXT(a_byte_three_cycles, in_valid_i && in_ready && !restart_i, ##2 tail_q, "byte did not reach tail in three cycles")
  `RC4SC_ASSERT_NEXT(a_tail_kept, tail_q && out_valid_q && !out_ready_i, tail_q, "pending result dropped while output full")
  `RC4SC_ASSERT_NEXT(a_sched_end, state_q == ST_K_W2 && cnt_q == rc4sc_pkg::LAST_IDX, state_q == ST_RD_J && i_q == AW'(1) && j_q == '0, "schedule did not hand over with i = 1, j = 0")
  `RC4SC_ASSERT_NEXT(a_accept_clears_tail, in_valid_i && in_ready, !tail_q, "accept left a tail pending")

endmodule

@@ src/rc4_stream_cipher_top.sv @@
// ----------------------------------------------------------------------------
// RC4 stream cipher - top level
// A byte without restart passes ST_RD_J, ST_RD_K and an ST_IDLE tail that waits
//   while the output is full, then shows on out_valid_o; the next byte is taken
//   in that tail, after three dependent reads S[i], S[j], S[S[i]+S[j]] on the
//   single read port of the permutation RAM. Restart adds the identity fill, then
//   256 swaps through ST_K_ACC, ST_K_W1, ST_K_W2. Reset: identity fill, in_ready_o
//   low meanwhile; key registers are cleared, key length reads 16; config writes taken always.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc4_stream_cipher_top #(
  // longest key in use; the key register space itself is fixed at 16 bytes
  parameter int unsigned MAX_KEY_BYTES = rc4sc_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port, no wait, no read-back
  input  logic                             cfg_we_i,
  input  logic [rc4sc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rc4sc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input transaction
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [rc4sc_pkg::DATA_W-1:0]     data_byte_i,
  input  logic                             restart_i,
  input  logic                             last_byte_i,
  // output transaction
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [rc4sc_pkg::DATA_W-1:0]     out_byte_o,
  output logic                             last_out_o
);

  rc4sc_pkg::key_cfg_t             key_cfg;
  rc4sc_pkg::mem_req_t             mem_req;
  logic [rc4sc_pkg::DATA_W-1:0]    mem_rdata;

  // Key registers. A changed key only matters at the next restart, since
  // the engine reads it during the schedule alone.
  rc4sc_cfg #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .key_cfg_o  (key_cfg)
  );

  // Permutation S: 256 x 8, one write and one registered read per cycle.
  // The engine bypasses same-cycle write/read collisions itself.
  rc4sc_ram #(
    .WIDTH (rc4sc_pkg::DATA_W),
    .DEPTH (rc4sc_pkg::PERM_DEPTH)
  ) u_perm_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  // Sequencer: clear pass, key schedule and keystream generation. The
  // result register frees the input side: the next byte is taken in the
  // same cycle the previous result is loaded, and the final write of the
  // swap overlaps that byte's first read.
  rc4sc_engine #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_cfg_i   (key_cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .restart_i   (restart_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_out_o  (last_out_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

endmodule
